// ----- design/sorted_insert_draw_queue_top_macros.svh -----
// Assertion macros shared by the checker.
`ifndef SORTED_INSERT_DRAW_QUEUE_TOP_MACROS_SVH
`define SORTED_INSERT_DRAW_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sidq_pkg.sv -----
`timescale 1ns / 1ps

package sidq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam int CMD_W    = 52;
    localparam int RESULT_W = 62;

    typedef struct packed {
        logic [7:0]         layer;
        logic signed [15:0] zindex;
        logic [15:0]        handle;
    } t_entry;

    typedef struct packed {
        logic [9:0]         index;
        logic [15:0]        handle;
        logic signed [15:0] zindex;
        logic [7:0]         layer;
        logic [1:0]         opcode;
    } t_cmd;

    typedef struct packed {
        logic [9:0]         count;
        logic [15:0]        out_handle;
        logic signed [15:0] out_zindex;
        logic [7:0]         out_layer;
        logic [9:0]         slot;
        logic [1:0]         status;
    } t_result;

    // True when the stored entry must move after the new one.
    function automatic logic sorts_after(t_entry stored, t_entry fresh);
        logic res;
        if (stored.layer < fresh.layer) begin
            res = 1'b1;
        end else if (stored.layer > fresh.layer) begin
            res = 1'b0;
        end else begin
            res = ($signed(fresh.zindex) < $signed(stored.zindex));
        end
        return res;
    endfunction

endpackage

// ----- design/sidq_mem.sv -----
`timescale 1ns / 1ps

module sidq_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  sidq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output sidq_pkg::t_entry o_rdata
);
    import sidq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sidq_ctrl.sv -----
`timescale 1ns / 1ps

module sidq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sidq_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output sidq_pkg::t_result o_result,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output sidq_pkg::t_entry  o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  sidq_pkg::t_entry  i_mem_rdata
);
    import sidq_pkg::*;

    localparam int CW = (AW > 10) ? AW : 10;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_RDATA = 2'd3;

    localparam logic [AW-1:0] FULL_AT = AW'(DEPTH - 1);

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_q, n_q;
    t_entry        r_new, n_new;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          w_accept;
    logic [CW-1:0] w_idx_ext;
    logic [CW-1:0] w_cnt_ext;
    logic [CW-1:0] w_cnt_inc_ext;
    logic [CW-1:0] w_q_ext;
    t_entry        w_cmd_entry;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    assign w_idx_ext     = CW'(i_cmd.index);
    assign w_cnt_ext     = CW'(r_count);
    assign w_cnt_inc_ext = CW'(r_count + AW'(1));
    assign w_q_ext       = CW'(r_q);

    assign w_cmd_entry.layer  = i_cmd.layer;
    assign w_cmd_entry.zindex = i_cmd.zindex;
    assign w_cmd_entry.handle = i_cmd.handle;

    // The scan reads slot q-2 while it writes slot q, so a read never sees a
    // slot that is being rewritten in the same cycle.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_q         = r_q;
        n_new       = r_new;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_q;
        o_mem_wdata = r_new;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out       = '0;
                    n_out.count = w_cnt_ext[9:0];
                    unique case (i_cmd.opcode)
                        OP_INSERT: begin
                            if (r_count >= FULL_AT) begin
                                n_out.status = STAT_FULL;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_new = w_cmd_entry;
                                if (r_count == '0) begin
                                    n_q     = '0;
                                    n_state = S_PLACE;
                                end else begin
                                    o_mem_raddr = r_count - AW'(1);
                                    n_q         = r_count;
                                    n_state     = S_SCAN;
                                end
                            end
                        end
                        OP_READ: begin
                            if (w_idx_ext >= w_cnt_ext) begin
                                n_out.status = STAT_RANGE;
                                n_out.slot   = i_cmd.index;
                                n_out_valid  = 1'b1;
                            end else begin
                                o_mem_raddr = w_idx_ext[AW-1:0];
                                n_q         = w_idx_ext[AW-1:0];
                                n_state     = S_RDATA;
                            end
                        end
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out.count = '0;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_mem_raddr = r_q - AW'(2);
                o_mem_we    = 1'b1;
                if (sorts_after(i_mem_rdata, r_new)) begin
                    // shift the entry that sorts after up one slot
                    o_mem_wdata = i_mem_rdata;
                    n_q         = r_q - AW'(1);
                    if (r_q == AW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    o_mem_wdata      = r_new;
                    n_count          = r_count + AW'(1);
                    n_out.status     = STAT_OK;
                    n_out.slot       = w_q_ext[9:0];
                    n_out.out_layer  = r_new.layer;
                    n_out.out_zindex = r_new.zindex;
                    n_out.out_handle = r_new.handle;
                    n_out.count      = w_cnt_inc_ext[9:0];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_PLACE: begin
                o_mem_we         = 1'b1;
                o_mem_wdata      = r_new;
                n_count          = r_count + AW'(1);
                n_out.status     = STAT_OK;
                n_out.slot       = w_q_ext[9:0];
                n_out.out_layer  = r_new.layer;
                n_out.out_zindex = r_new.zindex;
                n_out.out_handle = r_new.handle;
                n_out.count      = w_cnt_inc_ext[9:0];
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            S_RDATA: begin
                n_out.status     = STAT_OK;
                n_out.slot       = w_q_ext[9:0];
                n_out.out_layer  = i_mem_rdata.layer;
                n_out.out_zindex = i_mem_rdata.zindex;
                n_out.out_handle = i_mem_rdata.handle;
                n_out.count      = w_cnt_ext[9:0];
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_new <= n_new;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- design/sorted_insert_draw_queue_top.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | tdata fields (low bit up)
// s_axis    | in        | opcode[1:0] layer[9:2] zindex[25:10] handle[41:26] index[51:42]
// m_axis    | out       | status[1:0] slot[11:2] out_layer[19:12] out_zindex[35:20]
//           |           | out_handle[51:36] count[61:52]
//
// Read, clear, full and out-of-range beats do not scan the memory.
// An insert walks the sorted memory from the top entry down, one slot per cycle
// through the single write port.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
// One item is in flight at a time; a result beat waits in an output register,
// and the next item is taken in the cycle that beat leaves.

module sorted_insert_draw_queue_top #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // opcode, layer, zindex, handle, index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status, slot, out_layer, out_zindex, out_handle, count
);
    import sidq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          w_cmd;
    t_result       w_result;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [AW-1:0] w_mem_raddr;
    t_entry        w_mem_wdata;
    t_entry        w_mem_rdata;

    assign w_cmd        = t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign m_axis_tdata = {(64 - RESULT_W)'(0), w_result};

    sidq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    sidq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

// ----- design/sidq_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_insert_draw_queue_top_macros.svh"

module sidq_checker #(
    parameter int DEPTH = 1024
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    import sidq_pkg::*;

    t_result w_res;
    t_cmd    w_cmd;
    logic    w_small;

    assign w_res   = t_result'(m_axis_tdata[RESULT_W-1:0]);
    assign w_cmd   = t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign w_small = (DEPTH <= 1024);

    // hold a stalled result beat
    `SIDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // a dropped insert carries no entry
    `SIDQ_ASSERT_NOW(a_full_empty, i_clk, i_rst_n, m_axis_tvalid && (w_res.status == STAT_FULL), (w_res.slot == 10'd0) && (w_res.out_layer == 8'd0) && (w_res.out_handle == 16'd0), "full result carries data")

    // a successful slot lies below the count, or is zero
    `SIDQ_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, m_axis_tvalid && w_small && (w_res.status == STAT_OK), (w_res.slot < w_res.count) || (w_res.slot == 10'd0), "slot beyond count")

    // a clear leaves an empty queue
    `SIDQ_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (w_cmd.opcode == OP_CLEAR), m_axis_tvalid && (w_res.count == 10'd0) && (w_res.status == STAT_OK), "clear did not empty queue")

endmodule

bind sorted_insert_draw_queue_top sidq_checker #(.DEPTH(DEPTH)) u_sidq_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sidq_pkg::*;

    localparam int         DEPTH     = 1024;
    localparam int         KEEP_MAX  = DEPTH - 1;
    localparam int         FILL_LEN  = 120;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_cmd cmd;
        int   gap;
        bit   wait_idle;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // opcode, layer, zindex, handle, index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // status, slot, out_layer, out_zindex, out_handle, count

    // Predicted queue contents
    t_entry      draw_list [DEPTH];
    int unsigned draw_len = 0;

    t_result     result_fifo [$];
    t_beat       cmd_queue [$];
    int          fail_cnt = 0;
    int          beats_out = 0;
    logic        cmd_taken = 1'b0;
    int          gap_left = 0;
    bit          gen_steady = 1'b0;

    int          hold_left = 0;
    int          stall_left = 0;
    int          long_holds = 0;
    int          rx_phase = 0;
    bit          rx_steady = 1'b0;

    sorted_insert_draw_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Apply one command to the predicted queue and return the result it yields.
    function automatic t_result apply_draw_cmd(t_cmd c);
        t_result     r;
        t_entry      ne;
        t_entry      prev;
        int unsigned pos;
        bit          placed;
        r = '0;
        case (c.opcode)
            OP_INSERT: begin
                if (draw_len >= KEEP_MAX) begin
                    r.status = STAT_FULL;
                end else begin
                    ne.layer  = c.layer;
                    ne.zindex = c.zindex;
                    ne.handle = c.handle;
                    pos = draw_len;
                    placed = 1'b0;
                    // shift up every entry that sorts after the new one; ties stay below
                    while (pos > 0 && !placed) begin
                        prev = draw_list[pos - 1];
                        if (prev.layer > ne.layer || (prev.layer == ne.layer &&
                                $signed(ne.zindex) >= $signed(prev.zindex))) begin
                            placed = 1'b1;
                        end else begin
                            draw_list[pos] = prev;
                            pos--;
                        end
                    end
                    draw_list[pos] = ne;
                    draw_len++;
                    r.status     = STAT_OK;
                    r.slot       = pos[9:0];
                    r.out_layer  = ne.layer;
                    r.out_zindex = ne.zindex;
                    r.out_handle = ne.handle;
                end
            end
            OP_READ: begin
                r.slot = c.index;
                if (c.index >= draw_len) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.status     = STAT_OK;
                    r.out_layer  = draw_list[c.index].layer;
                    r.out_zindex = draw_list[c.index].zindex;
                    r.out_handle = draw_list[c.index].handle;
                end
            end
            OP_CLEAR: begin
                draw_len = 0;
            end
            default: begin
            end
        endcase
        r.count = draw_len[9:0];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cmd noise_cmd(logic [1:0] op);
        t_cmd c;
        c.opcode = op;
        c.layer  = 8'($urandom);
        c.zindex = 16'($urandom);
        c.handle = 16'($urandom);
        c.index  = 10'($urandom);
        return c;
    endfunction

    function automatic t_cmd insert_cmd(logic [7:0] layer, logic signed [15:0] z,
                                        logic [15:0] h);
        t_cmd c;
        c = noise_cmd(OP_INSERT);
        c.layer  = layer;
        c.zindex = z;
        c.handle = h;
        return c;
    endfunction

    function automatic t_cmd read_cmd(logic [9:0] idx);
        t_cmd c;
        c = noise_cmd(OP_READ);
        c.index = idx;
        return c;
    endfunction

    task automatic post_cmd(t_cmd c, bit hold_until_idle = 1'b0);
        t_beat b;
        b.cmd       = c;
        b.wait_idle = hold_until_idle;
        b.gap       = (gen_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        cmd_queue.push_back(b);
    endtask

    // Sender: hold a beat until taken, then idle for its gap.
    always @(negedge i_clk) begin : sender
        t_beat nxt;
        logic  next_valid;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!s_axis_tvalid || cmd_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].wait_idle && result_fifo.size() > 0)) begin
                nxt = cmd_queue.pop_front();
                s_axis_tdata <= {4'b0000, nxt.cmd};
                gap_left = nxt.gap;
                next_valid = 1'b1;
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // Receiver: random stalls, quiet stretches, and two long hold-offs.
    always @(negedge i_clk) begin : receiver
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (long_holds == 0 && beats_out >= 60) begin
                hold_left = 400;
                long_holds = 1;
            end else if (long_holds == 1 && beats_out >= 350) begin
                hold_left = 300;
                long_holds = 2;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                rdy = 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 20)
                    stall_left = idle_len();
            end
            rx_phase++;
            if (rx_phase == 300) begin
                rx_phase = 0;
                rx_steady = ($urandom_range(0, 3) == 0);
            end
        end
        m_axis_tready <= rdy;
    end

    // Check result beats against the oldest prediction, then predict accepted commands.
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[RESULT_W-1:0];
                beats_out++;
                if (result_fifo.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result beat: %h", got);
                end else begin
                    want = result_fifo.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.out_layer !== want.out_layer ||
                        got.out_zindex !== want.out_zindex ||
                        got.out_handle !== want.out_handle || got.count !== want.count) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"result mismatch at beat %0d: expected st=%0d slot=%0d ",
                                      "layer=%0d z=%0d handle=%h count=%0d, got st=%0d ",
                                      "slot=%0d layer=%0d z=%0d handle=%h count=%0d"},
                                     beats_out, want.status, want.slot, want.out_layer,
                                     $signed(want.out_zindex), want.out_handle, want.count,
                                     got.status, got.slot, got.out_layer,
                                     $signed(got.out_zindex), got.out_handle, got.count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cmd_taken = 1'b1;
                result_fifo.push_back(apply_draw_cmd(s_axis_tdata[CMD_W-1:0]));
            end
        end
    end

    initial begin : stimulus
        logic [7:0]         layer_pool [4];
        logic signed [15:0] z_pool [5];
        logic [7:0]         lay;
        logic signed [15:0] zv;
        int                 issued;
        int                 run_len;
        int                 est_len;
        int                 pick;

        layer_pool = '{8'd0, 8'd1, 8'd2, 8'd255};
        z_pool     = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};

        // Directed: empty queue, key extremes, ties, every opcode.
        post_cmd(read_cmd(10'd0));
        post_cmd(noise_cmd(OP_UNUSED));
        post_cmd(insert_cmd(8'd0, 16'sh8000, 16'h0000));
        post_cmd(insert_cmd(8'd255, 16'sh7fff, 16'hffff));
        post_cmd(insert_cmd(8'd255, 16'sh8000, 16'h8001));
        post_cmd(insert_cmd(8'd128, 16'sd0, 16'h1234));
        post_cmd(insert_cmd(8'd128, 16'sd0, 16'h5678));
        post_cmd(insert_cmd(8'd128, -16'sd1, 16'h9abc));
        post_cmd(insert_cmd(8'd0, 16'sh7fff, 16'h0f0f));
        for (int i = 0; i <= 7; i++)
            post_cmd(read_cmd(i[9:0]));
        post_cmd(read_cmd(10'h3ff));
        post_cmd(noise_cmd(OP_UNUSED));
        post_cmd(noise_cmd(OP_CLEAR));
        post_cmd(read_cmd(10'd0));

        // Build a deep queue, mostly with entries that sort last so inserts stay short.
        post_cmd(noise_cmd(OP_CLEAR), 1'b1);
        for (int i = 0; i < FILL_LEN; i++) begin
            if ($urandom_range(0, 9) == 0)
                post_cmd(insert_cmd(8'($urandom), 16'($urandom), 16'($urandom)));
            else
                post_cmd(insert_cmd(8'd0, 16'sh7fff, 16'($urandom)));
        end
        post_cmd(noise_cmd(OP_UNUSED));
        post_cmd(read_cmd(10'(FILL_LEN - 1)));
        post_cmd(read_cmd(10'(FILL_LEN)));
        post_cmd(read_cmd(10'd0));
        for (int i = 0; i < 8; i++)
            post_cmd(read_cmd(10'($urandom)));
        post_cmd(noise_cmd(OP_CLEAR));

        // Random runs: usually a clear, then inserts with colliding keys mixed with reads, unused opcodes and clears.
        issued = 0;
        while (issued < 420) begin
            gen_steady = ($urandom_range(0, 4) == 0);
            est_len = 0;
            if ($urandom_range(0, 9) != 0)
                post_cmd(noise_cmd(OP_CLEAR), $urandom_range(0, 5) == 0);
            run_len = $urandom_range(4, 40);
            for (int k = 0; k < run_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    lay = 8'($urandom);
                    zv  = 16'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        lay = layer_pool[$urandom_range(0, 3)];
                    if ($urandom_range(0, 9) < 4)
                        zv = z_pool[$urandom_range(0, 4)];
                    post_cmd(insert_cmd(lay, zv, 16'($urandom)));
                    est_len++;
                end else if (pick < 94) begin
                    if ($urandom_range(0, 99) < 85)
                        post_cmd(read_cmd(10'($urandom_range(0, est_len))));
                    else
                        post_cmd(read_cmd(10'($urandom)));
                end else if (pick < 97) begin
                    post_cmd(noise_cmd(OP_UNUSED));
                end else begin
                    post_cmd(noise_cmd(OP_CLEAR));
                    est_len = 0;
                end
            end
            issued += run_len + 1;
        end
        gen_steady = 1'b0;

        while (cmd_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (result_fifo.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
